### hw/rtl/ffce_pkg.sv
// package for the 3d component eraser
// types and constants shared by all modules, and the state enum of the back part
package ffce_pkg;
  localparam int DimX = 32;
  localparam int DimY = 32;
  localparam int DimZ = 32;
  localparam int AddrBits = 15;
  localparam int VolSize = DimX * DimY * DimZ;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ERASED = 2'd1;
  localparam logic [1:0] ST_BG = 2'd2;
  localparam logic [1:0] ST_OVER = 2'd3;

  localparam logic [2:0] REG_SX = 3'd0;
  localparam logic [2:0] REG_SY = 3'd1;
  localparam logic [2:0] REG_SZ = 3'd2;
  localparam logic [2:0] REG_MA = 3'd3;
  localparam logic [2:0] REG_BUD = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    logic [14:0] voxel_index;
    logic [15:0] label_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] label_out;
    logic [1:0] status;
    logic [15:0] component_size;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SEED_RD, S_SEED_CHK, S_CLR, S_POP, S_POP_WAIT, S_NB, S_NB_RD, S_NB_CHK,
    S_ERASE, S_ERASE_CHK, S_READ_WAIT, S_OUT
  } st_t;
endpackage

### hw/rtl/flood_fill_component_erase_3d.sv
// top level of the 3d connected component eraser
// holds the configuration registers; uses ffce_front, ffce_back and ffce_pkg
//
// After the two-entry input queue, a voxel write passes S_IDLE and S_OUT, and a read
// S_IDLE, S_READ_WAIT and S_OUT. A run item first clears the 32768-entry mark memory
// one entry a cycle; the search then passes S_POP and S_POP_WAIT per popped voxel, S_NB
// per neighbor and S_NB_RD and S_NB_CHK per in-range neighbor checked, and when the
// component is erased a sweep through S_ERASE and S_ERASE_CHK per voxel covers the
// whole volume. A background seed skips both; single-port memories set this order.
// One result item comes out per item; during a run the queue fills and stalls the input.
module flood_fill_component_erase_3d (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  ffce_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output ffce_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import ffce_pkg::*;
  logic [4:0] sx_r, sy_r, sz_r;
  logic ma_r;
  logic [15:0] bud_r;
  logic q_valid, q_take;
  in_item_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= 5'd0; sy_r <= 5'd0; sz_r <= 5'd0; ma_r <= 1'b0; bud_r <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SX: sx_r <= cfg_data[4:0];
        REG_SY: sy_r <= cfg_data[4:0];
        REG_SZ: sz_r <= cfg_data[4:0];
        REG_MA: ma_r <= cfg_data[0];
        REG_BUD: bud_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ffce_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .q_valid, .q_take, .q_data
  );

  ffce_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_data,
    .seed_x(sx_r), .seed_y(sy_r), .seed_z(sz_r), .match_any(ma_r),
    .voxel_budget(bud_r), .out_valid, .out_ready, .out_data
  );
endmodule

### hw/rtl/ffce_front.sv
// front part: accepts items into a two-entry queue
// depends on ffce_pkg
module ffce_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  ffce_pkg::in_item_t in_data,
  output logic q_valid,
  input  logic q_take,
  output ffce_pkg::in_item_t q_data
);
  import ffce_pkg::*;
  in_item_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign in_ready = cnt_r != 2'd2;
  assign q_valid = cnt_r != 2'd0;
  assign q_data = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### hw/rtl/ffce_back.sv
// back part: volume, mark and stack memories and the fill sequencer
// depends on ffce_pkg
module ffce_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_take,
  input  ffce_pkg::in_item_t q_data,
  input  logic [4:0] seed_x,
  input  logic [4:0] seed_y,
  input  logic [4:0] seed_z,
  input  logic match_any,
  input  logic [15:0] voxel_budget,
  output logic out_valid,
  input  logic out_ready,
  output ffce_pkg::out_item_t out_data
);
  import ffce_pkg::*;
  logic [15:0] vol [VolSize];
  logic mark [VolSize];
  logic [14:0] stk [VolSize];
  logic [15:0] vol_q;
  logic mark_q;
  logic [14:0] stk_q;

  st_t st_r, st_nxt;
  logic [15:0] sp_r, sp_nxt, cnt_r, cnt_nxt;
  logic [15:0] seedlab_r, seedlab_nxt;
  logic [14:0] cur_r, cur_nxt, na_r, na_nxt;
  logic [15:0] ptr_r, ptr_nxt;
  logic [2:0] k_r, k_nxt;
  out_item_t res_r, res_nxt;
  logic vwe, mwe, swe;
  logic [14:0] vaddr, maddr, saddr, swd;
  logic [15:0] vwd;
  logic mwd;
  logic [4:0] cx, cy, cz;
  logic nok;
  logic [14:0] nadr;
  logic nb_join;

  always_ff @(posedge clk) begin
    if (vwe) vol[vaddr] <= vwd;
    vol_q <= vol[vaddr];
    if (mwe) mark[maddr] <= mwd;
    mark_q <= mark[maddr];
    if (swe) stk[saddr] <= swd;
    stk_q <= stk[saddr];
  end

  assign cx = cur_r[4:0];
  assign cy = cur_r[9:5];
  assign cz = cur_r[14:10];
  always_comb begin
    nok = 1'b1;
    nadr = cur_r;
    case (k_r)
      3'd0: begin nok = cx != 5'd0; nadr = cur_r - 15'd1; end
      3'd1: begin nok = cx != 5'd31; nadr = cur_r + 15'd1; end
      3'd2: begin nok = cy != 5'd0; nadr = cur_r - 15'd32; end
      3'd3: begin nok = cy != 5'd31; nadr = cur_r + 15'd32; end
      3'd4: begin nok = cz != 5'd0; nadr = cur_r - 15'd1024; end
      3'd5: begin nok = cz != 5'd31; nadr = cur_r + 15'd1024; end
      default: nok = 1'b0;
    endcase
  end
  assign nb_join = match_any ? (vol_q != 16'd0) : (vol_q == seedlab_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= 16'd0;
      res_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      res_r <= res_nxt;
    end
    sp_r <= sp_nxt;
    seedlab_r <= seedlab_nxt;
    cur_r <= cur_nxt;
    na_r <= na_nxt;
    ptr_r <= ptr_nxt;
    k_r <= k_nxt;
  end

  assign out_valid = st_r == S_OUT;
  assign out_data = res_r;

  always_comb begin
    st_nxt = st_r;
    sp_nxt = sp_r;
    cnt_nxt = cnt_r;
    seedlab_nxt = seedlab_r;
    cur_nxt = cur_r;
    na_nxt = na_r;
    ptr_nxt = ptr_r;
    k_nxt = k_r;
    res_nxt = res_r;
    q_take = 1'b0;
    vwe = 1'b0; vaddr = q_data.voxel_index; vwd = q_data.label_in;
    mwe = 1'b0; maddr = ptr_r[14:0]; mwd = 1'b0;
    swe = 1'b0; saddr = sp_r[14:0]; swd = na_r;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          res_nxt.label_out = 16'd0;
          res_nxt.status = ST_DONE;
          res_nxt.component_size = cnt_r;
          case (q_data.op)
            OP_WRITE: begin vwe = 1'b1; st_nxt = S_OUT; end
            OP_READ: st_nxt = S_READ_WAIT;
            OP_RUN: begin
              ptr_nxt = 16'd0;
              cnt_nxt = 16'd0;
              st_nxt = S_CLR;
            end
            default: st_nxt = S_OUT;
          endcase
        end
      end
      S_READ_WAIT: begin
        res_nxt.label_out = vol_q;
        st_nxt = S_OUT;
      end
      S_CLR: begin
        mwe = 1'b1;
        ptr_nxt = ptr_r + 16'd1;
        if (ptr_r == 16'(VolSize - 1)) st_nxt = S_SEED_RD;
      end
      S_SEED_RD: begin
        vaddr = {seed_z, seed_y, seed_x};
        st_nxt = S_SEED_CHK;
      end
      S_SEED_CHK: begin
        seedlab_nxt = vol_q;
        if (vol_q == 16'd0) begin
          res_nxt.status = ST_BG;
          res_nxt.component_size = 16'd0;
          st_nxt = S_OUT;
        end else begin
          mwe = 1'b1; maddr = {seed_z, seed_y, seed_x}; mwd = 1'b1;
          swe = 1'b1; saddr = 15'd0; swd = {seed_z, seed_y, seed_x};
          sp_nxt = 16'd1;
          cnt_nxt = 16'd1;
          st_nxt = S_POP;
        end
      end
      S_POP: begin
        if (sp_r == 16'd0) begin
          res_nxt.component_size = cnt_r;
          if (cnt_r > voxel_budget) begin
            res_nxt.status = ST_OVER;
            st_nxt = S_OUT;
          end else begin
            res_nxt.status = ST_ERASED;
            ptr_nxt = 16'd0;
            st_nxt = S_ERASE;
          end
        end else begin
          saddr = 15'(sp_r - 16'd1);
          sp_nxt = sp_r - 16'd1;
          st_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cur_nxt = stk_q;
        k_nxt = 3'd0;
        st_nxt = S_NB;
      end
      S_NB: begin
        if (k_r == 3'd6) st_nxt = S_POP;
        else if (!nok) k_nxt = k_r + 3'd1;
        else begin
          vaddr = nadr; maddr = nadr; na_nxt = nadr;
          st_nxt = S_NB_RD;
        end
      end
      S_NB_RD: begin
        vaddr = na_r; maddr = na_r;
        st_nxt = S_NB_CHK;
      end
      S_NB_CHK: begin
        if (!mark_q && nb_join) begin
          mwe = 1'b1; maddr = na_r; mwd = 1'b1;
          swe = 1'b1;
          sp_nxt = sp_r + 16'd1;
          if (cnt_r != 16'hFFFF) cnt_nxt = cnt_r + 16'd1;
        end
        k_nxt = k_r + 3'd1;
        st_nxt = S_NB;
      end
      S_ERASE: begin
        maddr = ptr_r[14:0];
        st_nxt = S_ERASE_CHK;
      end
      S_ERASE_CHK: begin
        if (mark_q) begin vwe = 1'b1; vaddr = ptr_r[14:0]; vwd = 16'd0; end
        ptr_nxt = ptr_r + 16'd1;
        if (ptr_r == 16'(VolSize - 1)) st_nxt = S_OUT;
        else st_nxt = S_ERASE;
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule
